FILE: src/scb_pkg.sv
// Package for the sample capture buffer with statistics.
// Holds the sizes, command and status codes, and the payload structs.
// Used by every module in src except scb_ram.
`timescale 1ns / 1ps

package scb_pkg;

  localparam int DEPTH       = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int AW      = $clog2(DEPTH);            // store address
  localparam int IW      = AW + 1;                   // index or count, may equal DEPTH
  localparam int RES_W   = SAMPLE_BITS + 1;
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int SUM_W   = SAMPLE_BITS + IW;
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1 + AW;
  localparam int V_W     = SQ_W + IW;
  localparam int ROOT_W  = (V_W + 1) / 2;
  localparam int DIV_W   = ROOT_W;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_READ   = 3'd1,
    CMD_MEAN   = 3'd2,
    CMD_RMS    = 3'd3,
    CMD_P2P    = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  localparam logic [1:0] CFG_CAPACITY = 2'd0;
  localparam logic [1:0] CFG_SKIP     = 2'd1;
  localparam logic [1:0] CFG_CHANNEL  = 2'd2;
  localparam logic [1:0] CFG_CIRCULAR = 2'd3;

  typedef struct packed {
    logic [2:0]                    command;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic signed [SAMPLE_BITS-1:0] sample_c;
    logic signed [SAMPLE_BITS-1:0] sample_d;
    logic [IW-1:0]                 range_first;
    logic [IW-1:0]                 range_last;
    logic [IW-1:0]                 point_count;
    logic [AW-1:0]                 point_number;
  } scb_cmd_t;

  typedef struct packed {
    logic signed [RES_W-1:0] result_value;
    logic [IW-1:0]           point_index;
    logic [IW-1:0]           valid_count;
    logic [1:0]              status;
  } scb_res_t;

endpackage

FILE: src/scb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module scb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/scb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on scb_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module scb_div
  import scb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [IW-1:0]    den_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic             run_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DIV_W-1:0] quo_q;
  logic [IW-1:0]    rem_q, den_q;
  logic [IW:0]      trial, diff;
  logic             ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(DIV_W);
        quo_q <= num_i;
        rem_q <= '0;
        den_q <= den_i;
      end else if (run_q) begin
        rem_q <= ge ? diff[IW-1:0] : trial[IW-1:0];
        quo_q <= {quo_q[DIV_W-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/scb_isqrt.sv
// Integer square root, one result bit per cycle (floor of the root).
// Depends on scb_pkg for the operand and root widths.
`timescale 1ns / 1ps

module scb_isqrt
  import scb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  logic [V_W-1:0]    val_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int SW2 = 2 * ROOT_W;
  localparam logic [SW2-1:0] TOP_BIT = SW2'(1) << (SW2 - 2);

  logic           run_q, done_q;
  logic [SW2-1:0] val_q, r_q, bit_q, trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        val_q <= SW2'(val_i);
        r_q   <= '0;
        bit_q <= TOP_BIT;
      end else if (run_q) begin
        if (val_q >= trial) begin
          val_q <= val_q - trial;
          r_q   <= (r_q >> 1) + bit_q;
        end else begin
          r_q   <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[ROOT_W-1:0];

endmodule

FILE: src/sample_capture_buffer_stats_core.sv
// Top level of the sample capture buffer with statistics.
// Depends on scb_pkg, scb_ram, scb_div and scb_isqrt.
//
// Usage:
//   Configuration: write cfg_data_i to register cfg_idx_i when cfg_we_i is
//   high (0 capacity, 1 skip count, 2 channel, 3 circular mode). Write only
//   while busy is low and no result is pending.
//   Commands: a transaction is taken at a clock edge with start high and busy
//   low. Each command gives exactly one result on res_o, marked by done_o for
//   one cycle; the receiver cannot stall it.
//   Sequencing: append, clear and unused codes answer in the cycle after start,
//   with busy staying low, so appends run at one row per cycle. Read point
//   passes through the prepare, read-address and read-wait states, adding
//   the serial divider when the window is decimated. Peak-to-peak is set
//   by the one-read-per-cycle walk over the store; mean adds the divider;
//   AC RMS adds the multiply stage, the bit-serial square root and the
//   divider.
//   Reset: capacity is full depth, skipping off, channel 0, linear mode and
//   the store is empty. Store contents are not cleared; only captured
//   entries are ever read.
`timescale 1ns / 1ps

module sample_capture_buffer_stats_core
  import scb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [IW-1:0] cfg_data_i,
  input  logic          start,
  output logic          busy,
  input  scb_cmd_t      cmd_i,
  output logic          done_o,
  output scb_res_t      res_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_PREP   = 10'b00_0000_0010,
    S_DIVGO  = 10'b00_0000_0100,
    S_DIVW   = 10'b00_0000_1000,
    S_RDADDR = 10'b00_0001_0000,
    S_RDWAIT = 10'b00_0010_0000,
    S_WALK   = 10'b00_0100_0000,
    S_MULT   = 10'b00_1000_0000,
    S_VSUB   = 10'b01_0000_0000,
    S_SQRTW  = 10'b10_0000_0000
  } state_e;

  state_e state_q;

  logic [IW-1:0] cap_q, skipf_q, fill_q, skip_q;
  logic [1:0]    chsel_q;
  logic          circ_q;
  logic [AW-1:0] wp_q;

  scb_cmd_t      cmd_q;
  logic [AW-1:0] base_q, addr_q;
  logic [IW-1:0] pidx_q, first_q, ic_q;
  logic          rdv_q, sqv_q, seen_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [SQ_W-1:0]               sq_q;
  logic [PROD_W-1:0]             sqp_q;
  logic signed [SAMPLE_BITS-1:0] lo_q, hi_q;
  logic [V_W-1:0]   nsq_q, ss_q;
  logic [DIV_W-1:0] divn_q;
  logic [IW-1:0]    divd_q;
  logic             done_q;
  scb_res_t         res_q;

  function automatic logic [IW-1:0] umin(input logic [IW-1:0] a, input logic [IW-1:0] b);
    umin = (a < b) ? a : b;
  endfunction

  function automatic scb_res_t make_res(input logic [RES_W-1:0] val, input logic [IW-1:0] pidx,
                                        input logic [IW-1:0] vc, input status_e st);
    scb_res_t r;
    r.result_value = val;
    r.point_index  = pidx;
    r.valid_count  = vc;
    r.status       = st;
    make_res = r;
  endfunction

  // Visible count and hidden count
  logic [IW-1:0] hid, n_w;
  assign hid = umin(skip_q, fill_q);
  assign n_w = fill_q - hid;

  // Append path
  logic signed [SAMPLE_BITS-1:0] samp;
  logic          full, drop;
  logic [IW-1:0] wp_inc, fill_nx, skip_nx, hid_nx, vis_nx;
  logic [AW-1:0] wp_nx;

  always_comb begin
    case (chsel_q)
      2'd0:    samp = cmd_i.sample_a;
      2'd1:    samp = cmd_i.sample_b;
      2'd2:    samp = cmd_i.sample_c;
      default: samp = cmd_i.sample_d;
    endcase
  end

  assign full    = fill_q >= cap_q;
  assign drop    = (cap_q == '0) || (full && !circ_q);
  assign wp_inc  = IW'(wp_q) + IW'(1);
  assign wp_nx   = (wp_inc == cap_q) ? '0 : wp_inc[AW-1:0];
  assign fill_nx = full ? fill_q : fill_q + IW'(1);
  assign skip_nx = (full && skip_q != '0) ? skip_q - IW'(1) : skip_q;
  assign hid_nx  = umin(skip_nx, fill_nx);
  assign vis_nx  = fill_nx - hid_nx;

  logic accept, ram_we;
  assign accept = start && (state_q == S_IDLE);
  assign ram_we = accept && (cmd_i.command == CMD_APPEND) && !drop;
  assign busy   = (state_q != S_IDLE);

  // Window checks for a point read
  logic [IW-1:0]      first_c, last_c, avail, cnt_lim;
  logic               rfail, dec;
  logic [AW+IW-1:0]   prod_w;

  assign first_c = umin(cmd_q.range_first, n_w);
  assign last_c  = umin(cmd_q.range_last, n_w);
  assign avail   = last_c - first_c;
  assign cnt_lim = umin(avail, cmd_q.point_count);
  assign rfail   = (last_c <= first_c) || (cmd_q.point_count == '0) ||
                   (IW'(cmd_q.point_number) >= cnt_lim);
  assign dec     = (avail > cmd_q.point_count) && (cmd_q.point_count > IW'(1));
  assign prod_w  = cmd_q.point_number * avail;

  // Position of the oldest visible sample
  logic [IW:0]   old_s, old_r, base_s, base_r;
  logic [AW-1:0] base_c;
  assign old_s  = (IW+1)'(wp_q) + (IW+1)'(cap_q) - (IW+1)'(fill_q);
  assign old_r  = (old_s >= (IW+1)'(cap_q)) ? old_s - (IW+1)'(cap_q) : old_s;
  assign base_s = old_r + (IW+1)'(hid);
  assign base_r = (base_s >= (IW+1)'(cap_q)) ? base_s - (IW+1)'(cap_q) : base_s;
  assign base_c = base_r[AW-1:0];

  logic [IW:0]   pos_s, pos_r;
  assign pos_s = (IW+1)'(base_q) + (IW+1)'(pidx_q);
  assign pos_r = (pos_s >= (IW+1)'(cap_q)) ? pos_s - (IW+1)'(cap_q) : pos_s;

  // Store walk
  logic          issue;
  logic [IW-1:0] addr_inc;
  logic [AW-1:0] addr_nx;
  assign issue    = (state_q == S_WALK) && (ic_q != n_w);
  assign addr_inc = IW'(addr_q) + IW'(1);
  assign addr_nx  = (addr_inc == cap_q) ? '0 : addr_inc[AW-1:0];

  logic [SAMPLE_BITS-1:0] rdata;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [PROD_W-1:0] x_sq;
  assign x    = signed'(rdata);
  assign x_sq = x * x;

  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  assign ram_re    = (state_q == S_RDADDR) || issue;
  assign ram_raddr = (state_q == S_RDADDR) ? pos_r[AW-1:0] : addr_q;

  scb_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (samp),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // Arithmetic units
  logic             div_go, div_done;
  logic [DIV_W-1:0] quo;
  assign div_go = (state_q == S_DIVGO);

  scb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (divn_q),
    .den_i  (divd_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  logic              sqrt_go, sqrt_done;
  logic [ROOT_W-1:0] root;
  logic [V_W-1:0]    var_w;
  assign sqrt_go = (state_q == S_VSUB);
  assign var_w   = nsq_q - ss_q;

  scb_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (sqrt_go),
    .val_i  (var_w),
    .done_o (sqrt_done),
    .root_o (root)
  );

  logic [V_W-1:0]             nsq_w;
  logic signed [2*SUM_W-1:0]  ss_w;
  logic [SUM_W-1:0]           abs_sum;
  logic [RES_W-1:0]           q_res;
  assign nsq_w   = n_w * sq_q;
  assign ss_w    = sum_q * sum_q;
  assign abs_sum = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign q_res   = RES_W'(quo);

  logic [IW-1:0] cap_wr;
  assign cap_wr = (cfg_data_i > IW'(DEPTH)) ? IW'(DEPTH) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= IW'(DEPTH);
      skipf_q <= '0;
      chsel_q <= '0;
      circ_q  <= 1'b0;
      wp_q    <= '0;
      fill_q  <= '0;
      skip_q  <= '0;
      rdv_q   <= 1'b0;
      sqv_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      rdv_q  <= issue;
      sqv_q  <= rdv_q;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY: begin
            cap_q  <= cap_wr;
            fill_q <= '0;
            wp_q   <= '0;
            skip_q <= umin(skipf_q, cap_wr);
          end
          CFG_SKIP: begin
            skipf_q <= cfg_data_i;
            skip_q  <= umin(cfg_data_i, cap_q);
          end
          CFG_CHANNEL:  chsel_q <= cfg_data_i[1:0];
          CFG_CIRCULAR: circ_q  <= cfg_data_i[0];
          default: ;
        endcase
      end

      case (state_q)
        S_IDLE: begin
          if (start) begin
            case (cmd_i.command)
              CMD_APPEND: begin
                done_q <= 1'b1;
                if (drop) begin
                  res_q <= make_res('0, '0, n_w, ST_DROP);
                end else begin
                  wp_q   <= wp_nx;
                  fill_q <= fill_nx;
                  skip_q <= skip_nx;
                  res_q  <= make_res('0, '0, vis_nx, ST_OK);
                end
              end
              CMD_CLEAR: begin
                fill_q <= '0;
                wp_q   <= '0;
                skip_q <= umin(skipf_q, cap_q);
                done_q <= 1'b1;
                res_q  <= make_res('0, '0, '0, ST_OK);
              end
              CMD_READ, CMD_MEAN, CMD_RMS, CMD_P2P: begin
                cmd_q   <= cmd_i;
                state_q <= S_PREP;
              end
              default: begin
                done_q <= 1'b1;
                res_q  <= make_res('0, '0, n_w, ST_EMPTY);
              end
            endcase
          end
        end

        S_PREP: begin
          base_q <= base_c;
          if (cmd_q.command == CMD_READ) begin
            if (rfail) begin
              done_q  <= 1'b1;
              res_q   <= make_res('0, '0, n_w, ST_EMPTY);
              state_q <= S_IDLE;
            end else begin
              first_q <= first_c;
              if (dec) begin
                divn_q  <= DIV_W'(prod_w);
                divd_q  <= cmd_q.point_count;
                state_q <= S_DIVGO;
              end else begin
                pidx_q  <= first_c + IW'(cmd_q.point_number);
                state_q <= S_RDADDR;
              end
            end
          end else if (n_w == '0) begin
            done_q  <= 1'b1;
            res_q   <= make_res('0, '0, n_w, ST_EMPTY);
            state_q <= S_IDLE;
          end else begin
            addr_q  <= base_c;
            ic_q    <= '0;
            sum_q   <= '0;
            sq_q    <= '0;
            seen_q  <= 1'b0;
            state_q <= S_WALK;
          end
        end

        S_DIVGO: state_q <= S_DIVW;

        S_DIVW: begin
          if (div_done) begin
            case (cmd_q.command)
              CMD_READ: begin
                pidx_q  <= first_q + quo[IW-1:0];
                state_q <= S_RDADDR;
              end
              CMD_MEAN: begin
                done_q  <= 1'b1;
                res_q   <= make_res(sum_q[SUM_W-1] ? -q_res : q_res, '0, n_w, ST_OK);
                state_q <= S_IDLE;
              end
              default: begin
                done_q  <= 1'b1;
                res_q   <= make_res(q_res, '0, n_w, ST_OK);
                state_q <= S_IDLE;
              end
            endcase
          end
        end

        S_RDADDR: state_q <= S_RDWAIT;

        S_RDWAIT: begin
          done_q  <= 1'b1;
          res_q   <= make_res(RES_W'(x), pidx_q, n_w, ST_OK);
          state_q <= S_IDLE;
        end

        S_WALK: begin
          if (issue) begin
            addr_q <= addr_nx;
            ic_q   <= ic_q + IW'(1);
          end
          if (rdv_q) begin
            sum_q  <= sum_q + SUM_W'(x);
            sqp_q  <= $unsigned(x_sq);
            seen_q <= 1'b1;
            if (!seen_q || x < lo_q) lo_q <= x;
            if (!seen_q || x > hi_q) hi_q <= x;
          end
          if (sqv_q) begin
            sq_q <= sq_q + SQ_W'(sqp_q);
          end
          // All reads issued and the accumulate pipeline drained
          if (!issue && !rdv_q && !sqv_q) begin
            case (cmd_q.command)
              CMD_P2P: begin
                done_q  <= 1'b1;
                res_q   <= make_res(RES_W'(hi_q) - RES_W'(lo_q), '0, n_w, ST_OK);
                state_q <= S_IDLE;
              end
              CMD_MEAN: begin
                divn_q  <= DIV_W'(abs_sum);
                divd_q  <= n_w;
                state_q <= S_DIVGO;
              end
              default: state_q <= S_MULT;
            endcase
          end
        end

        S_MULT: begin
          nsq_q   <= nsq_w;
          ss_q    <= V_W'($unsigned(ss_w));
          state_q <= S_VSUB;
        end

        S_VSUB: state_q <= S_SQRTW;

        S_SQRTW: begin
          if (sqrt_done) begin
            divn_q  <= DIV_W'(root);
            divd_q  <= n_w;
            state_q <= S_DIVGO;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
